FILE: design/iqu_pkg.sv
package iqu_pkg;

  localparam int OpW  = 36;
  localparam int AccW = 72;
  localparam int PcW  = 7;

  localparam logic signed [31:0] OneQ30  = 32'sd1073741824;
  localparam logic signed [31:0] HalfQ30 = 32'sd536870912;

  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_PERIOD     = 2'd2;
  localparam logic [1:0] REG_INTEG_LIM  = 2'd3;

  localparam logic [PcW-1:0] PC_GAIN = 7'd42;
  localparam logic [PcW-1:0] PC_HALF = 7'd48;
  localparam logic [PcW-1:0] PC_DONE = 7'd85;

  typedef enum logic [2:0] {
    OP_MAC, OP_WB, OP_ROOT, OP_BRACC, OP_BRKI, OP_NSHIFT, OP_SZERO, OP_DONE
  } op_t;

  typedef enum logic [1:0] {AM_LD, AM_LDN, AM_ADD, AM_SUB} acc_mode_t;

  typedef enum logic [1:0] {SH0, SH24, SH25, SH30} shift_t;

  typedef enum logic [4:0] {
    SRC_AX, SRC_AY, SRC_AZ, SRC_Q0, SRC_Q1, SRC_Q2, SRC_Q3,
    SRC_NX, SRC_NY, SRC_NZ, SRC_HVX, SRC_HVY, SRC_HVZ,
    SRC_EX, SRC_EY, SRC_EZ, SRC_KI, SRC_KP, SRC_T,
    SRC_GX, SRC_GY, SRC_GZ, SRC_HX, SRC_HY, SRC_HZ,
    SRC_N0, SRC_N1, SRC_N2, SRC_N3, SRC_TMP
  } src_t;

  typedef enum logic [4:0] {
    D_S, D_HVX, D_HVY, D_HVZ, D_EX, D_EY, D_EZ, D_TMP,
    D_IX, D_IY, D_IZ, D_GX, D_GY, D_GZ, D_HX, D_HY, D_HZ,
    D_N0, D_N1, D_N2, D_N3, D_NX, D_NY, D_NZ,
    D_Q0, D_Q1, D_Q2, D_Q3
  } dst_t;

  typedef struct packed {
    op_t            op;
    src_t           sa;
    src_t           sb;
    acc_mode_t      mode;
    dst_t           dst;
    shift_t         sh;
    logic [PcW-1:0] tgt;
  } uop_t;

  function automatic uop_t mk(op_t op, src_t sa, src_t sb, acc_mode_t m, dst_t d,
                              shift_t sh, logic [PcW-1:0] t);
    uop_t u;
    u.op = op; u.sa = sa; u.sb = sb; u.mode = m; u.dst = d; u.sh = sh; u.tgt = t;
    return u;
  endfunction

  function automatic uop_t mac(src_t a, src_t b, acc_mode_t m);
    return mk(OP_MAC, a, b, m, D_S, SH0, '0);
  endfunction

  function automatic uop_t wb(dst_t d, shift_t sh);
    return mk(OP_WB, SRC_AX, SRC_AX, AM_LD, d, sh, '0);
  endfunction

  function automatic uop_t rt(src_t a, dst_t d);
    return mk(OP_ROOT, a, a, AM_LD, d, SH0, '0);
  endfunction

  function automatic uop_t ctl(op_t op, logic [PcW-1:0] t);
    return mk(op, SRC_AX, SRC_AX, AM_LD, D_S, SH0, t);
  endfunction

  function automatic logic [1:0] dst_lane(dst_t d);
    logic [1:0] k;
    case (d)
      D_HVY, D_EY, D_IY, D_GY, D_HY, D_N1, D_NY, D_Q1: k = 2'd1;
      D_HVZ, D_EZ, D_IZ, D_GZ, D_HZ, D_N2, D_NZ, D_Q2: k = 2'd2;
      D_N3, D_Q3:                                        k = 2'd3;
      default:                                           k = 2'd0;
    endcase
    return k;
  endfunction

  // Sequencer program
  function automatic uop_t ucode(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = ctl(OP_BRACC, PC_HALF);
      7'd1:  u = mac(SRC_AX, SRC_AX, AM_LD);
      7'd2:  u = mac(SRC_AY, SRC_AY, AM_ADD);
      7'd3:  u = mac(SRC_AZ, SRC_AZ, AM_ADD);
      7'd4:  u = wb(D_S, SH0);
      7'd5:  u = mac(SRC_AX, SRC_AX, AM_LD);
      7'd6:  u = rt(SRC_AX, D_NX);
      7'd7:  u = mac(SRC_AY, SRC_AY, AM_LD);
      7'd8:  u = rt(SRC_AY, D_NY);
      7'd9:  u = mac(SRC_AZ, SRC_AZ, AM_LD);
      7'd10: u = rt(SRC_AZ, D_NZ);
      7'd11: u = mac(SRC_Q1, SRC_Q3, AM_LD);
      7'd12: u = mac(SRC_Q0, SRC_Q2, AM_SUB);
      7'd13: u = wb(D_HVX, SH30);
      7'd14: u = mac(SRC_Q0, SRC_Q1, AM_LD);
      7'd15: u = mac(SRC_Q2, SRC_Q3, AM_ADD);
      7'd16: u = wb(D_HVY, SH30);
      7'd17: u = mac(SRC_Q0, SRC_Q0, AM_LD);
      7'd18: u = mac(SRC_Q3, SRC_Q3, AM_ADD);
      7'd19: u = wb(D_HVZ, SH30);
      7'd20: u = mac(SRC_NY, SRC_HVZ, AM_LD);
      7'd21: u = mac(SRC_NZ, SRC_HVY, AM_SUB);
      7'd22: u = wb(D_EX, SH30);
      7'd23: u = mac(SRC_NZ, SRC_HVX, AM_LD);
      7'd24: u = mac(SRC_NX, SRC_HVZ, AM_SUB);
      7'd25: u = wb(D_EY, SH30);
      7'd26: u = mac(SRC_NX, SRC_HVY, AM_LD);
      7'd27: u = mac(SRC_NY, SRC_HVX, AM_SUB);
      7'd28: u = wb(D_EZ, SH30);
      7'd29: u = ctl(OP_BRKI, PC_GAIN);
      7'd30: u = mac(SRC_KI, SRC_EX, AM_LD);
      7'd31: u = wb(D_TMP, SH30);
      7'd32: u = mac(SRC_TMP, SRC_T, AM_LD);
      7'd33: u = wb(D_IX, SH24);
      7'd34: u = mac(SRC_KI, SRC_EY, AM_LD);
      7'd35: u = wb(D_TMP, SH30);
      7'd36: u = mac(SRC_TMP, SRC_T, AM_LD);
      7'd37: u = wb(D_IY, SH24);
      7'd38: u = mac(SRC_KI, SRC_EZ, AM_LD);
      7'd39: u = wb(D_TMP, SH30);
      7'd40: u = mac(SRC_TMP, SRC_T, AM_LD);
      7'd41: u = wb(D_IZ, SH24);
      7'd42: u = mac(SRC_KP, SRC_EX, AM_LD);
      7'd43: u = wb(D_GX, SH30);
      7'd44: u = mac(SRC_KP, SRC_EY, AM_LD);
      7'd45: u = wb(D_GY, SH30);
      7'd46: u = mac(SRC_KP, SRC_EZ, AM_LD);
      7'd47: u = wb(D_GZ, SH30);
      7'd48: u = mac(SRC_GX, SRC_T, AM_LD);
      7'd49: u = wb(D_HX, SH25);
      7'd50: u = mac(SRC_GY, SRC_T, AM_LD);
      7'd51: u = wb(D_HY, SH25);
      7'd52: u = mac(SRC_GZ, SRC_T, AM_LD);
      7'd53: u = wb(D_HZ, SH25);
      7'd54: u = mac(SRC_Q1, SRC_HX, AM_LDN);
      7'd55: u = mac(SRC_Q2, SRC_HY, AM_SUB);
      7'd56: u = mac(SRC_Q3, SRC_HZ, AM_SUB);
      7'd57: u = wb(D_N0, SH24);
      7'd58: u = mac(SRC_Q0, SRC_HX, AM_LD);
      7'd59: u = mac(SRC_Q2, SRC_HZ, AM_ADD);
      7'd60: u = mac(SRC_Q3, SRC_HY, AM_SUB);
      7'd61: u = wb(D_N1, SH24);
      7'd62: u = mac(SRC_Q0, SRC_HY, AM_LD);
      7'd63: u = mac(SRC_Q1, SRC_HZ, AM_SUB);
      7'd64: u = mac(SRC_Q3, SRC_HX, AM_ADD);
      7'd65: u = wb(D_N2, SH24);
      7'd66: u = mac(SRC_Q0, SRC_HZ, AM_LD);
      7'd67: u = mac(SRC_Q1, SRC_HY, AM_ADD);
      7'd68: u = mac(SRC_Q2, SRC_HX, AM_SUB);
      7'd69: u = wb(D_N3, SH24);
      7'd70: u = ctl(OP_NSHIFT, '0);
      7'd71: u = mac(SRC_N0, SRC_N0, AM_LD);
      7'd72: u = mac(SRC_N1, SRC_N1, AM_ADD);
      7'd73: u = mac(SRC_N2, SRC_N2, AM_ADD);
      7'd74: u = mac(SRC_N3, SRC_N3, AM_ADD);
      7'd75: u = wb(D_S, SH0);
      7'd76: u = ctl(OP_SZERO, PC_DONE);
      7'd77: u = mac(SRC_N0, SRC_N0, AM_LD);
      7'd78: u = rt(SRC_N0, D_Q0);
      7'd79: u = mac(SRC_N1, SRC_N1, AM_LD);
      7'd80: u = rt(SRC_N1, D_Q1);
      7'd81: u = mac(SRC_N2, SRC_N2, AM_LD);
      7'd82: u = rt(SRC_N2, D_Q2);
      7'd83: u = mac(SRC_N3, SRC_N3, AM_LD);
      7'd84: u = rt(SRC_N3, D_Q3);
      default: u = ctl(OP_DONE, '0);
    endcase
    return u;
  endfunction

endpackage

FILE: design/imu_attitude_quaternion_update_core.sv
// Channel  Signals                                  Direction  Moves
// in       in_valid, in_stall, gyro_*, accel_*      sink       one IMU sample per transfer
// out      out_valid, out_stall, quat_*             source     one quaternion per transfer
// cfg      cfg_we, cfg_index, cfg_data              sink       one register write per cycle
//
// A sample with a zero accel vector skips the accel normalization and the feedback terms,
// a zero integral gain skips the integral update, and each renormalizing shift adds a
// shift step to the run; a zero quaternion skips the four roots.
// The run time is set by the shared 36x36 multiplier and by the bit-serial root unit:
// 61 divide steps plus 31 square-root steps per normalized component. in_stall is high
// from an accepted transfer until its result is loaded into the output register, so the
// next sample can be accepted at the edge after out_valid rises; a held result stalls only
// the finish of the next sample. Reset is synchronous and restores the identity attitude,
// zero integrals and the default registers.
module imu_attitude_quaternion_update_core
  import iqu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] gyro_x,
  input  logic signed [31:0] gyro_y,
  input  logic signed [31:0] gyro_z,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_SQRT = 4'b1000
  } state_t;

  state_t state;
  logic [PcW-1:0] pc;
  logic ph;

  logic [30:0] kp, ki, ilim;
  logic [24:0] tper;

  logic signed [31:0] a_r [3];
  logic signed [31:0] q_r [4];
  logic signed [31:0] ig_r [3];
  logic signed [31:0] nv_r [3];
  logic signed [31:0] hv_r [3];
  logic signed [31:0] e_r [3];
  logic signed [31:0] h_r [3];
  logic signed [35:0] g_r [3];
  logic signed [33:0] tmp_r;
  logic signed [40:0] n_r [4];
  logic [63:0] s_r;

  logic signed [AccW-1:0] prod, acc;

  logic [64:0] dr;
  logic [59:0] dq;
  logic        dbit;
  logic [61:0] rad;
  logic [35:0] rem;
  logic [30:0] root;
  logic [5:0]  cnt;
  logic        rsgn;
  dst_t        rdst;

  uop_t u;
  logic signed [OpW-1:0] op_a, op_b;
  logic signed [AccW-1:0] x;
  logic [1:0] lane;
  logic signed [38:0] isum_w;
  logic signed [31:0] isum, iclamp;
  logic signed [32:0] lim_s;
  logic [64:0] dt, dsub;
  logic dge;
  logic [35:0] rem_t, trial;
  logic sge;
  logic [30:0] root_new;
  logic signed [31:0] rval;
  logic n_fit;

  function automatic logic signed [OpW-1:0] opnd(input src_t sel);
    logic signed [OpW-1:0] v;
    case (sel)
      SRC_AX:  v = OpW'(a_r[0]);
      SRC_AY:  v = OpW'(a_r[1]);
      SRC_AZ:  v = OpW'(a_r[2]);
      SRC_Q0:  v = OpW'(q_r[0]);
      SRC_Q1:  v = OpW'(q_r[1]);
      SRC_Q2:  v = OpW'(q_r[2]);
      SRC_Q3:  v = OpW'(q_r[3]);
      SRC_NX:  v = OpW'(nv_r[0]);
      SRC_NY:  v = OpW'(nv_r[1]);
      SRC_NZ:  v = OpW'(nv_r[2]);
      SRC_HVX: v = OpW'(hv_r[0]);
      SRC_HVY: v = OpW'(hv_r[1]);
      SRC_HVZ: v = OpW'(hv_r[2]);
      SRC_EX:  v = OpW'(e_r[0]);
      SRC_EY:  v = OpW'(e_r[1]);
      SRC_EZ:  v = OpW'(e_r[2]);
      SRC_KI:  v = $signed({5'b0, ki});
      SRC_KP:  v = $signed({5'b0, kp});
      SRC_T:   v = $signed({11'b0, tper});
      SRC_GX:  v = g_r[0];
      SRC_GY:  v = g_r[1];
      SRC_GZ:  v = g_r[2];
      SRC_HX:  v = OpW'(h_r[0]);
      SRC_HY:  v = OpW'(h_r[1]);
      SRC_HZ:  v = OpW'(h_r[2]);
      SRC_N0:  v = $signed(n_r[0][OpW-1:0]);
      SRC_N1:  v = $signed(n_r[1][OpW-1:0]);
      SRC_N2:  v = $signed(n_r[2][OpW-1:0]);
      SRC_N3:  v = $signed(n_r[3][OpW-1:0]);
      SRC_TMP: v = OpW'(tmp_r);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(AccW'(32'sh7fffffff))) r = 32'sh7fffffff;
    else if (v < $signed(-AccW'(33'sh080000000))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic fits(input logic signed [40:0] v);
    return (v <= 41'sd2147483647) && (v >= -41'sd2147483647);
  endfunction

  always_comb begin
    u    = ucode(pc);
    op_a = opnd(u.sa);
    op_b = opnd(u.sb);
    lane = dst_lane(u.dst);
    case (u.sh)
      SH24:    x = acc >>> 24;
      SH25:    x = acc >>> 25;
      SH30:    x = acc >>> 30;
      default: x = acc;
    endcase
    isum_w = 39'(ig_r[lane[1] ? 2'd2 : {1'b0, lane[0]}]) + 39'($signed(x[37:0]));
    if (isum_w > 39'sd2147483647) isum = 32'sh7fffffff;
    else if (isum_w < -39'sd2147483648) isum = 32'sh80000000;
    else isum = isum_w[31:0];
    lim_s = $signed({2'b0, ilim});
    if (33'(isum) > lim_s) iclamp = lim_s[31:0];
    else if (33'(isum) < -lim_s) iclamp = 32'(-lim_s);
    else iclamp = isum;

    dt   = {dr[63:0], dbit};
    dge  = dt >= {1'b0, s_r};
    dsub = dt - {1'b0, s_r};

    rem_t    = {rem[33:0], rad[61:60]};
    trial    = {3'b0, root, 2'b01};
    sge      = rem_t >= trial;
    root_new = {root[29:0], sge};
    rval     = rsgn ? -$signed({1'b0, root_new}) : $signed({1'b0, root_new});

    n_fit = fits(n_r[0]) && fits(n_r[1]) && fits(n_r[2]) && fits(n_r[3]);
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      ph        <= 1'b0;
      out_valid <= 1'b0;
      kp        <= 31'd16777216;
      ki        <= '0;
      tper      <= 25'd167772;
      ilim      <= 31'h7fffffff;
      q_r[0]    <= OneQ30;
      q_r[1]    <= '0;
      q_r[2]    <= '0;
      q_r[3]    <= '0;
      for (int i = 0; i < 3; i++) ig_r[i] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:  kp   <= cfg_data;
          REG_INTEG_GAIN: ki   <= cfg_data;
          REG_PERIOD:     tper <= cfg_data[24:0];
          REG_INTEG_LIM:  ilim <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            a_r[0] <= accel_x;
            a_r[1] <= accel_y;
            a_r[2] <= accel_z;
            g_r[0] <= OpW'(gyro_x);
            g_r[1] <= OpW'(gyro_y);
            g_r[2] <= OpW'(gyro_z);
            pc     <= '0;
            ph     <= 1'b0;
            state  <= ST_RUN;
          end
        end

        ST_RUN: begin
          case (u.op)
            OP_MAC: begin
              if (!ph) begin
                ph <= 1'b1;
              end else begin
                case (u.mode)
                  AM_LD:   acc <= prod;
                  AM_LDN:  acc <= -prod;
                  AM_ADD:  acc <= acc + prod;
                  default: acc <= acc - prod;
                endcase
                ph <= 1'b0;
                pc <= pc + 1'b1;
              end
            end
            OP_WB: begin
              case (u.dst)
                D_S:                 s_r        <= acc[63:0];
                D_HVX, D_HVY:        hv_r[lane] <= x[31:0];
                D_HVZ:               hv_r[2]    <= x[31:0] - HalfQ30;
                D_EX, D_EY, D_EZ:    e_r[lane]  <= x[31:0];
                D_TMP:               tmp_r      <= x[33:0];
                D_IX, D_IY, D_IZ: begin
                  g_r[lane]  <= g_r[lane] + OpW'(isum);
                  ig_r[lane] <= iclamp;
                end
                D_GX, D_GY, D_GZ:    g_r[lane]  <= g_r[lane] + x[OpW-1:0];
                D_HX, D_HY, D_HZ:    h_r[lane]  <= sat32(x);
                D_N0, D_N1, D_N2, D_N3:
                  n_r[lane] <= 41'(q_r[lane]) + $signed(x[40:0]);
                default: ;
              endcase
              pc <= pc + 1'b1;
            end
            OP_ROOT: begin
              rsgn  <= op_a[OpW-1];
              rdst  <= u.dst;
              dr    <= {2'b0, acc[63:1]};
              dbit  <= acc[0];
              cnt   <= '0;
              state <= ST_DIV;
            end
            OP_BRACC: begin
              if (a_r[0] == 0 && a_r[1] == 0 && a_r[2] == 0) pc <= u.tgt;
              else pc <= pc + 1'b1;
            end
            OP_BRKI: begin
              if (ki == '0) begin
                for (int i = 0; i < 3; i++) ig_r[i] <= '0;
                pc <= u.tgt;
              end else begin
                pc <= pc + 1'b1;
              end
            end
            OP_NSHIFT: begin
              if (n_fit) pc <= pc + 1'b1;
              else for (int i = 0; i < 4; i++) n_r[i] <= n_r[i] >>> 1;
            end
            OP_SZERO: begin
              if (s_r == '0) begin
                q_r[0] <= OneQ30;
                q_r[1] <= '0;
                q_r[2] <= '0;
                q_r[3] <= '0;
                pc     <= u.tgt;
              end else begin
                pc <= pc + 1'b1;
              end
            end
            default: begin
              if (!out_valid || !out_stall) begin
                quat_w    <= q_r[0];
                quat_x    <= q_r[1];
                quat_y    <= q_r[2];
                quat_z    <= q_r[3];
                out_valid <= 1'b1;
                state     <= ST_IDLE;
              end
            end
          endcase
        end

        ST_DIV: begin
          dr   <= dge ? dsub : dt;
          dq   <= {dq[58:0], dge};
          dbit <= 1'b0;
          cnt  <= cnt + 1'b1;
          if (cnt == 6'd60) begin
            rad   <= {1'b0, dq, dge};
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= ST_SQRT;
          end
        end

        ST_SQRT: begin
          rem  <= sge ? rem_t - trial : rem_t;
          root <= root_new;
          rad  <= {rad[59:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == 6'd30) begin
            case (rdst)
              D_NX, D_NY, D_NZ:       nv_r[dst_lane(rdst)] <= rval;
              D_Q0, D_Q1, D_Q2, D_Q3: q_r[dst_lane(rdst)]  <= rval;
              default: ;
            endcase
            pc    <= pc + 1'b1;
            state <= ST_RUN;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb
  import iqu_pkg::*;
();

  typedef struct {
    logic signed [31:0] gx, gy, gz, ax, ay, az;
  } imu_sample_t;

  typedef struct {
    logic signed [31:0] w, x, y, z;
  } quat_t;

  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic signed [31:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  imu_attitude_quaternion_update_core i_dut (.*);

  initial forever #4 clk = ~clk;

  // attitude and integrator mirror, register copies
  longint att_w, att_x, att_y, att_z, integ_x, integ_y, integ_z;
  longint kp_reg, ki_reg, period_reg, lim_reg;

  imu_sample_t pending_samples[$];
  quat_t expected_quats[$];
  int errors = 0;
  int n_accepted = 0;
  bit idle_on = 1'b1;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // trunc(v * 2^30 / sqrt(s)) by bitwise search
  function automatic longint unit_scale(longint v, bit [63:0] s);
    bit [63:0] mag, m, t;
    bit [127:0] lhs, rhs;
    mag = v < 0 ? 64'(-v) : 64'(v);
    rhs = {64'd0, mag * mag} << 60;
    m = '0;
    for (int b = 30; b >= 0; b--) begin
      t = m | (64'd1 << b);
      lhs = {64'd0, t * t} * {64'd0, s};
      if (lhs <= rhs) m = t;
    end
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_lim(longint v);
    if (v > lim_reg) return lim_reg;
    if (v < -lim_reg) return -lim_reg;
    return v;
  endfunction

  function automatic quat_t attitude_update(imu_sample_t smp);
    longint gx, gy, gz, ax, ay, az, q0, q1, q2, q3;
    longint nx, ny, nz, hvx, hvy, hvz, ex, ey, ez, ix, iy, iz;
    longint hx, hy, hz, n0, n1, n2, n3;
    bit [63:0] s;
    quat_t r;
    gx = smp.gx; gy = smp.gy; gz = smp.gz;
    ax = smp.ax; ay = smp.ay; az = smp.az;
    q0 = att_w; q1 = att_x; q2 = att_y; q3 = att_z;
    if (ax != 0 || ay != 0 || az != 0) begin
      s = 64'(ax * ax) + 64'(ay * ay) + 64'(az * az);
      nx = unit_scale(ax, s);
      ny = unit_scale(ay, s);
      nz = unit_scale(az, s);
      hvx = (q1 * q3 - q0 * q2) >>> 30;
      hvy = (q0 * q1 + q2 * q3) >>> 30;
      hvz = ((q0 * q0 + q3 * q3) >>> 30) - 64'sd536870912;
      ex = (ny * hvz - nz * hvy) >>> 30;
      ey = (nz * hvx - nx * hvz) >>> 30;
      ez = (nx * hvy - ny * hvx) >>> 30;
      if (ki_reg != 0) begin
        ix = sat32(integ_x + ((((ki_reg * ex) >>> 30) * period_reg) >>> 24));
        iy = sat32(integ_y + ((((ki_reg * ey) >>> 30) * period_reg) >>> 24));
        iz = sat32(integ_z + ((((ki_reg * ez) >>> 30) * period_reg) >>> 24));
        gx += ix; gy += iy; gz += iz;
        integ_x = clamp_lim(ix);
        integ_y = clamp_lim(iy);
        integ_z = clamp_lim(iz);
      end else begin
        integ_x = 0; integ_y = 0; integ_z = 0;
      end
      gx += (kp_reg * ex) >>> 30;
      gy += (kp_reg * ey) >>> 30;
      gz += (kp_reg * ez) >>> 30;
    end
    hx = sat32((gx * period_reg) >>> 25);
    hy = sat32((gy * period_reg) >>> 25);
    hz = sat32((gz * period_reg) >>> 25);
    n0 = q0 + ((-q1 * hx - q2 * hy - q3 * hz) >>> 24);
    n1 = q1 + ((q0 * hx + q2 * hz - q3 * hy) >>> 24);
    n2 = q2 + ((q0 * hy - q1 * hz + q3 * hx) >>> 24);
    n3 = q3 + ((q0 * hz + q1 * hy - q2 * hx) >>> 24);
    while (n0 >= 64'sd2147483648 || n0 < -64'sd2147483647 ||
           n1 >= 64'sd2147483648 || n1 < -64'sd2147483647 ||
           n2 >= 64'sd2147483648 || n2 < -64'sd2147483647 ||
           n3 >= 64'sd2147483648 || n3 < -64'sd2147483647) begin
      n0 = n0 >>> 1; n1 = n1 >>> 1; n2 = n2 >>> 1; n3 = n3 >>> 1;
    end
    s = 64'(n0 * n0) + 64'(n1 * n1) + 64'(n2 * n2) + 64'(n3 * n3);
    if (s == 0) begin
      q0 = OneQ30; q1 = 0; q2 = 0; q3 = 0;
    end else begin
      q0 = unit_scale(n0, s);
      q1 = unit_scale(n1, s);
      q2 = unit_scale(n2, s);
      q3 = unit_scale(n3, s);
    end
    att_w = q0; att_x = q1; att_y = q2; att_z = q3;
    r.w = q0[31:0]; r.x = q1[31:0]; r.y = q2[31:0]; r.z = q3[31:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_quats.push_back(attitude_update('{gyro_x, gyro_y, gyro_z,
                                                   accel_x, accel_y, accel_z}));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && !(idle_on && $urandom_range(99) < 23)) begin
          imu_sample_t smp;
          smp = pending_samples.pop_front();
          gyro_x <= smp.gx; gyro_y <= smp.gy; gyro_z <= smp.gz;
          accel_x <= smp.ax; accel_y <= smp.ay; accel_z <= smp.az;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_quats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: %0d %0d %0d %0d",
                                     quat_w, quat_x, quat_y, quat_z);
        end else begin
          quat_t e;
          e = expected_quats.pop_front();
          if (e.w !== quat_w || e.x !== quat_x || e.y !== quat_y || e.z !== quat_z) begin
            errors++;
            if (errors <= 10)
              $display("quat mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       e.w, e.x, e.y, e.z, quat_w, quat_x, quat_y, quat_z);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_accepted >= 600) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 23);
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    case (idx)
      REG_PROP_GAIN:  kp_reg = val & 64'h7FFF_FFFF;
      REG_INTEG_GAIN: ki_reg = val & 64'h7FFF_FFFF;
      REG_PERIOD:     period_reg = val & 64'h1FF_FFFF;
      default:        lim_reg = val & 64'h7FFF_FFFF;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled mid-cycle so that the driver's updates at the edge have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() > 0 || in_valid || expected_quats.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_small(int span);
    return $signed(32'($urandom_range(2 * span))) - span;
  endfunction

  function automatic imu_sample_t rnd_sample();
    imu_sample_t smp;
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      // plausible motion: a few rad/s, gravity near 1 g with noise
      smp = '{rnd_small(1 << 26), rnd_small(1 << 26), rnd_small(1 << 26),
              rnd_small(1 << 23), rnd_small(1 << 23), rnd_small(1 << 23)};
      case ($urandom_range(2))
        0: smp.ax += 32'sd16777216;
        1: smp.ay -= 32'sd16777216;
        default: smp.az += 32'sd16777216;
      endcase
    end else if (r < 80) begin
      smp = '{rnd_small(1 << 28), rnd_small(1 << 28), rnd_small(1 << 28), 0, 0, 0};
    end else if (r < 85) begin
      smp = '{rnd_small(1 << 20), rnd_small(1 << 20), rnd_small(1 << 20),
              rnd_small(4), rnd_small(4), rnd_small(4)};
    end else begin
      smp = '{$signed($urandom()), $signed($urandom()), $signed($urandom()),
              $signed($urandom()), $signed($urandom()), $signed($urandom())};
    end
    return smp;
  endfunction

  task automatic run_phase(longint kp, longint ki, longint per, longint lim, int count);
    wait_drained();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_PERIOD, per);
    write_reg(REG_INTEG_LIM, lim);
    pending_samples.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    pending_samples.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                                32'sh80000000, 32'sh80000000, 32'sh80000000});
    repeat (count) pending_samples.push_back(rnd_sample());
  endtask

  initial begin
    kp_reg = 16777216; ki_reg = 0; period_reg = 167772; lim_reg = 2147483647;
    att_w = 1073741824; att_x = 0; att_y = 0; att_z = 0;
    integ_x = 0; integ_y = 0; integ_z = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings, directed corners
    pending_samples.push_back('{0, 0, 0, 0, 0, 0});
    pending_samples.push_back('{32'sd16777216, 0, 0, 0, 0, 0});
    pending_samples.push_back('{0, 0, 0, 0, 0, 32'sd16777216});
    pending_samples.push_back('{0, 0, 0, 32'sd16777216, 0, 0});
    pending_samples.push_back('{0, 0, 0, 0, -32'sd16777216, 0});
    pending_samples.push_back('{0, 0, 0, 1, 0, 0});
    pending_samples.push_back('{0, 0, 0, -1, -1, -1});
    pending_samples.push_back('{32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0});
    pending_samples.push_back('{0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0});
    pending_samples.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0});
    pending_samples.push_back('{-1, -1, -1, 32'sh80000000, 0, 0});
    pending_samples.push_back('{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F,
                                32'shF0F0F0F0, 32'sh33333333, 32'shCCCCCCCC});
    pending_samples.push_back('{32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0,
                                32'sh0F0F0F0F, 32'shCCCCCCCC, 32'sh33333333});
    repeat (230) pending_samples.push_back(rnd_sample());

    run_phase(2147483647, 0, 167772, 2147483647, 240);
    run_phase(33554432, 3355443, 167772, 1000, 240);
    run_phase(0, 2147483647, 16777216, 2147483647, 240);
    run_phase(16777216, 1677721, 0, 0, 240);
    run_phase(8388608, 2147483647, 33554431, 5000000, 240);
    wait_drained();
    idle_on = 1'b0;
    run_phase(16777216, 335544, 167772, 16777216, 240);
    wait_drained();
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: imu_attitude_quaternion_update_core.f
design/iqu_pkg.sv
design/imu_attitude_quaternion_update_core.sv
tb/tb.sv
